// File: design/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg
// Shared types and constants of the go-to-point PI controller.
// ----------------------------------------------------------------------------
package gtp_pkg;

  localparam int CNT_W      = 5;
  localparam int SQRT_STEPS = 25;
  localparam int ATAN_N     = 24;
  localparam int CORD_W     = 58;
  localparam int SQ_W       = 50;
  localparam int ACC_W      = 66;
  localparam int INT_W      = 48;

  localparam logic [2:0] REG_TARGET_X      = 3'd0;
  localparam logic [2:0] REG_TARGET_Y      = 3'd1;
  localparam logic [2:0] REG_DRIVE_P_GAIN  = 3'd2;
  localparam logic [2:0] REG_DRIVE_I_GAIN  = 3'd3;
  localparam logic [2:0] REG_DRIVE_I_DECAY = 3'd4;
  localparam logic [2:0] REG_STEER_P_GAIN  = 3'd5;
  localparam logic [2:0] REG_STEER_I_GAIN  = 3'd6;
  localparam logic [2:0] REG_STEER_I_DECAY = 3'd7;

  localparam logic [2:0] PH_SUM   = 3'd0;
  localparam logic [2:0] PH_DLO   = 3'd1;
  localparam logic [2:0] PH_DHI   = 3'd2;
  localparam logic [2:0] PH_INT   = 3'd3;
  localparam logic [2:0] PH_PROP  = 3'd4;
  localparam logic [2:0] PH_GLO   = 3'd5;
  localparam logic [2:0] PH_GHI   = 3'd6;
  localparam logic [2:0] PH_CMD   = 3'd7;

  localparam logic [31:0] ATAN_TURNS [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic [15:0]        drive_p_gain;
    logic [15:0]        drive_i_gain;
    logic [15:0]        drive_i_decay;
    logic [15:0]        steer_p_gain;
    logic [15:0]        steer_i_gain;
    logic [15:0]        steer_i_decay;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             sq_x;
    logic             sq_y;
    logic             cord;
    logic             sqrt;
    logic             angle;
    logic             pi;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

endpackage

// File: design/gtp_datapath.sv
// ----------------------------------------------------------------------------
// gtp_datapath
// Error formation, CORDIC bearing, integer square root and shared PI unit.
// ----------------------------------------------------------------------------
module gtp_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  gtp_pkg::cmd_t      cmd,
  input  gtp_pkg::cfg_t      cfg,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic [15:0]        yaw,
  output logic signed [31:0] drive_command,
  output logic signed [31:0] steer_command,
  output logic signed [25:0] signed_distance,
  output logic signed [15:0] heading_error
);

  localparam int CW = gtp_pkg::CORD_W;
  localparam int AW = gtp_pkg::ACC_W;
  localparam int IW = gtp_pkg::INT_W;

  logic signed [24:0]      dx_r, dy_r;
  logic                    zero_r;
  logic [15:0]             yaw_r;
  logic signed [CW-1:0]    x_r, y_r;
  logic [31:0]             z_r;
  logic [gtp_pkg::SQ_W-1:0] v_r, r_r;
  logic signed [25:0]      dist_r;
  logic signed [15:0]      herr_r;
  logic signed [IW-1:0]    s_r;
  logic signed [AW-1:0]    acc_r;
  logic signed [IW-1:0]    dint_r, sint_r;
  logic signed [31:0]      dcmd_r, scmd_r;

  // load
  logic signed [24:0]   dxn, dyn;
  logic signed [CW-1:0] x0, y0;
  assign dxn = {cfg.target_x[23], cfg.target_x} - {pos_x[23], pos_x};
  assign dyn = {cfg.target_y[23], cfg.target_y} - {pos_y[23], pos_y};
  assign x0  = {{3{dyn[24]}}, dyn, 30'b0};
  assign y0  = {{3{dxn[24]}}, dxn, 30'b0};

  // squares of the offset magnitudes
  logic [23:0] adx, ady;
  logic [47:0] sqx, sqy;
  assign adx = dx_r[24] ? 24'(-dx_r) : dx_r[23:0];
  assign ady = dy_r[24] ? 24'(-dy_r) : dy_r[23:0];
  assign sqx = adx * adx;
  assign sqy = ady * ady;

  // cordic step, shift truncating toward zero
  logic [4:0]           sh;
  logic [CW-1:0]        rnd_x, rnd_y;
  logic signed [CW-1:0] xs, ys;
  assign sh    = cmd.cnt;
  assign rnd_x = x_r[CW-1] ? ((CW'(1) << sh) - CW'(1)) : '0;
  assign rnd_y = y_r[CW-1] ? ((CW'(1) << sh) - CW'(1)) : '0;
  assign xs    = (x_r + $signed(rnd_x)) >>> sh;
  assign ys    = (y_r + $signed(rnd_y)) >>> sh;

  // square root step
  logic [gtp_pkg::SQ_W-1:0] bitv, trial;
  logic [5:0]               bpos;
  assign bpos  = 6'd48 - {cmd.cnt, 1'b0};
  assign bitv  = gtp_pkg::SQ_W'(1) << bpos;
  assign trial = r_r + bitv;

  // bearing and heading error
  logic [15:0]        b16;
  logic signed [15:0] herr;
  logic               behind;
  logic signed [25:0] dist_abs;
  assign b16      = zero_r ? 16'd0 : (z_r[31:16] + {15'd0, z_r[15]});
  assign herr     = $signed(b16 - yaw_r);
  assign behind   = (herr <= -16'sd16384) || (herr >= 16'sd16384);
  assign dist_abs = {1'b0, r_r[24:0]};

  // shared pi unit
  logic                 sel;
  logic [2:0]           ph;
  logic signed [25:0]   e;
  logic signed [IW-1:0] iv;
  logic signed [IW:0]   sum;
  logic signed [IW-1:0] s_sat;
  logic signed [25:0]   mul_a;
  logic [15:0]          mul_b;
  logic signed [42:0]   prod;
  logic signed [AW-1:0] prod_x, prod_sh;
  logic signed [AW-1:0] inew_full, q;
  logic signed [31:0]   cmd_sat;

  assign sel = cmd.cnt[3];
  assign ph  = cmd.cnt[2:0];
  assign e   = sel ? {{10{herr_r[15]}}, herr_r} : dist_r;
  assign iv  = sel ? sint_r : dint_r;
  assign sum = {iv[IW-1], iv} + {{(IW-25){e[25]}}, e};
  assign s_sat = (sum[IW] != sum[IW-1]) ? {sum[IW], {(IW-1){~sum[IW]}}} : sum[IW-1:0];

  always_comb begin
    case (ph)
      gtp_pkg::PH_DLO: mul_a = {2'b00, s_r[23:0]};
      gtp_pkg::PH_DHI: mul_a = {{2{s_r[47]}}, s_r[47:24]};
      gtp_pkg::PH_GLO: mul_a = {2'b00, iv[23:0]};
      gtp_pkg::PH_GHI: mul_a = {{2{iv[47]}}, iv[47:24]};
      default:         mul_a = e;
    endcase
  end

  always_comb begin
    case (ph)
      gtp_pkg::PH_DLO, gtp_pkg::PH_DHI:
        mul_b = sel ? cfg.steer_i_decay : cfg.drive_i_decay;
      gtp_pkg::PH_GLO, gtp_pkg::PH_GHI:
        mul_b = sel ? cfg.steer_i_gain : cfg.drive_i_gain;
      default:
        mul_b = sel ? cfg.steer_p_gain : cfg.drive_p_gain;
    endcase
  end

  assign prod      = mul_a * $signed({1'b0, mul_b});
  assign prod_x    = {{(AW-43){prod[42]}}, prod};
  assign prod_sh   = prod_x <<< 24;
  assign inew_full = acc_r[AW-1] ? ((acc_r + AW'(65535)) >>> 16) : (acc_r >>> 16);
  assign q         = acc_r[AW-1] ? ((acc_r + AW'(255)) >>> 8) : (acc_r >>> 8);
  assign cmd_sat   = (q > AW'(32'sh7FFFFFFF)) ? 32'sh7FFFFFFF :
                     (q < -AW'(33'sh080000000)) ? 32'sh80000000 : q[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dint_r <= '0;
      sint_r <= '0;
    end else if (cmd.pi && ph == gtp_pkg::PH_INT) begin
      if (sel) begin
        sint_r <= inew_full[IW-1:0];
      end else begin
        dint_r <= inew_full[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r   <= dxn;
      dy_r   <= dyn;
      yaw_r  <= yaw;
      zero_r <= (dxn == 25'sd0) && (dyn == 25'sd0);
      if (dyn[24]) begin
        x_r <= -x0;
        y_r <= -y0;
        z_r <= 32'h8000_0000;
      end else begin
        x_r <= x0;
        y_r <= y0;
        z_r <= 32'd0;
      end
    end
    if (cmd.sq_x) begin
      v_r <= gtp_pkg::SQ_W'(sqx);
    end
    if (cmd.sq_y) begin
      v_r <= v_r + gtp_pkg::SQ_W'(sqy);
      r_r <= '0;
    end
    if (cmd.cord) begin
      if (!y_r[CW-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + gtp_pkg::ATAN_TURNS[sh];
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - gtp_pkg::ATAN_TURNS[sh];
      end
    end
    if (cmd.sqrt) begin
      if (v_r >= trial) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + bitv;
      end else begin
        r_r <= r_r >> 1;
      end
    end
    if (cmd.angle) begin
      herr_r <= herr;
      dist_r <= behind ? -dist_abs : dist_abs;
    end
    if (cmd.pi) begin
      case (ph)
        gtp_pkg::PH_SUM:  s_r <= s_sat;
        gtp_pkg::PH_DLO:  acc_r <= prod_x;
        gtp_pkg::PH_DHI:  acc_r <= acc_r + prod_sh;
        gtp_pkg::PH_PROP: acc_r <= prod_x;
        gtp_pkg::PH_GLO:  acc_r <= acc_r + prod_x;
        gtp_pkg::PH_GHI:  acc_r <= acc_r + prod_sh;
        gtp_pkg::PH_CMD: begin
          if (sel) begin
            scmd_r <= cmd_sat;
          end else begin
            dcmd_r <= cmd_sat;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign drive_command   = dcmd_r;
  assign steer_command   = scmd_r;
  assign signed_distance = dist_r;
  assign heading_error   = herr_r;

endmodule

// File: design/gtp_ctrl.sv
// ----------------------------------------------------------------------------
// gtp_ctrl
// Sequencer that steps the datapath through one pose sample.
// ----------------------------------------------------------------------------
module gtp_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_free,
  output logic          in_ready,
  output logic          out_load,
  output gtp_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQX   = 4'd1;
  localparam logic [3:0] S_SQY   = 4'd2;
  localparam logic [3:0] S_CORD  = 4'd3;
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_ANGLE = 4'd5;
  localparam logic [3:0] S_PI    = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  localparam logic [gtp_pkg::CNT_W-1:0] CORD_LAST = gtp_pkg::CNT_W'(CORDIC_STEPS - 1);
  localparam logic [gtp_pkg::CNT_W-1:0] SQRT_LAST = gtp_pkg::CNT_W'(gtp_pkg::SQRT_STEPS - 1);
  localparam logic [gtp_pkg::CNT_W-1:0] PI_LAST   = gtp_pkg::CNT_W'(15);

  logic [3:0]                state_r, state_nxt;
  logic [gtp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.cnt   = cnt_r;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        cmd.sq_x  = 1'b1;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.sq_y  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_CORD;
      end
      S_CORD: begin
        cmd.cord = 1'b1;
        if (cnt_r == CORD_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SQRT: begin
        cmd.sqrt = 1'b1;
        if (cnt_r == SQRT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_ANGLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ANGLE: begin
        cmd.angle = 1'b1;
        state_nxt = S_PI;
      end
      S_PI: begin
        cmd.pi = 1'b1;
        if (cnt_r == PI_LAST) begin
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// File: design/go_to_point_pi_controller.sv
// ----------------------------------------------------------------------------
// go_to_point_pi_controller
// Steers a robot pose toward a configured target with two leaky PI loops.
// ----------------------------------------------------------------------------
// One pose sample is taken at a time. It passes through two square steps, the
// CORDIC bearing at one iteration per cycle, a bit-serial square root, one
// angle step, a shared PI multiplier serving both loops and an output load.
// The result sits in an output register, so a new sample is taken as soon as
// the previous result has moved into it.
module go_to_point_pi_controller #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x[23:0], pos_y[47:24], yaw[63:48]
  input  logic [63:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // drive_command[31:0], steer_command[63:32], signed_distance[89:64],
  // heading_error[105:90], zero pad
  output logic [111:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_wdata
);

  gtp_pkg::cfg_t cfg_r;
  gtp_pkg::cmd_t cmd;
  logic          out_load, out_free;
  logic signed [31:0] drive_command, steer_command;
  logic signed [25:0] signed_distance;
  logic signed [15:0] heading_error;
  logic          out_valid_r;
  logic [105:0]  out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gtp_pkg::REG_TARGET_X:      cfg_r.target_x      <= cfg_wdata;
        gtp_pkg::REG_TARGET_Y:      cfg_r.target_y      <= cfg_wdata;
        gtp_pkg::REG_DRIVE_P_GAIN:  cfg_r.drive_p_gain  <= cfg_wdata[15:0];
        gtp_pkg::REG_DRIVE_I_GAIN:  cfg_r.drive_i_gain  <= cfg_wdata[15:0];
        gtp_pkg::REG_DRIVE_I_DECAY: cfg_r.drive_i_decay <= cfg_wdata[15:0];
        gtp_pkg::REG_STEER_P_GAIN:  cfg_r.steer_p_gain  <= cfg_wdata[15:0];
        gtp_pkg::REG_STEER_I_GAIN:  cfg_r.steer_i_gain  <= cfg_wdata[15:0];
        gtp_pkg::REG_STEER_I_DECAY: cfg_r.steer_i_decay <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  assign out_free = !out_valid_r || out_tready;

  gtp_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .in_ready (in_tready),
    .out_load (out_load),
    .cmd      (cmd)
  );

  gtp_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg             (cfg_r),
    .pos_x           (in_tdata[23:0]),
    .pos_y           (in_tdata[47:24]),
    .yaw             (in_tdata[63:48]),
    .drive_command   (drive_command),
    .steer_command   (steer_command),
    .signed_distance (signed_distance),
    .heading_error   (heading_error)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {heading_error, signed_distance, steer_command, drive_command};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten before transfer");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while sample in progress");

  a_load_only_idle_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> in_tready && out_tvalid)
    else $error("result load did not return to idle");

endmodule

// File: tb/tb_go_to_point_pi_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_go_to_point_pi_controller
// Pose samples are streamed into the go-to-point PI controller under random
// idling and long receiver stalls. A local model predicts distance, bearing
// error and both leaky PI commands. Each result transfer is checked field by
// field, and the gains, decays and targets change between phases.
// ----------------------------------------------------------------------------
module tb_go_to_point_pi_controller;

  localparam int STEPS       = 16;
  localparam int LATENCY     = STEPS + 60;
  localparam int WDOG_LIMIT  = 20000;
  localparam longint I48_MAX = 64'sd140737488355327;
  localparam longint I48_MIN = -64'sd140737488355328;

  typedef struct packed {
    logic [15:0]        yaw;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_x;
  } pose_t;

  typedef struct packed {
    logic signed [31:0] drive_cmd;
    logic signed [31:0] steer_cmd;
    logic signed [25:0] distance;
    logic signed [15:0] herr;
  } cmd_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [23:0]  cfg_wdata = '0;

  gtp_pkg::cfg_t cfg_m;
  longint   drive_integ, steer_integ;
  pose_t    pose_q[$];
  cmd_res_t expected_q[$];
  int       errors = 0;
  int       results_seen = 0;
  int       poses_sent = 0;
  int       idle_pct = 14;
  int       hold_off = 0;
  int       wdog = 0;
  bit       tx_pause = 1'b0;

  go_to_point_pi_controller #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic logic [31:0] compass_bearing(longint dx, longint dy);
    longint x, y, xs, ys;
    logic [31:0] z;
    x = dy * (64'sd1 <<< 30);
    y = dx * (64'sd1 <<< 30);
    z = 32'd0;
    if (dx == 0 && dy == 0) return 32'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x / (64'sd1 <<< i);
      ys = y / (64'sd1 <<< i);
      if (y >= 0) begin
        x += ys;
        y -= xs;
        z += gtp_pkg::ATAN_TURNS[i];
      end else begin
        x -= ys;
        y += xs;
        z -= gtp_pkg::ATAN_TURNS[i];
      end
    end
    return z;
  endfunction

  function automatic longint leaky_pi(inout longint integ, input longint e,
                                      input logic [15:0] pg, ig, decay);
    longint s, acc;
    s = clamp(integ + e, I48_MIN, I48_MAX);
    integ = (s * longint'(decay)) / 65536;
    acc = longint'(pg) * e + longint'(ig) * integ;
    return clamp(acc / 256, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic cmd_res_t predict_commands(pose_t p);
    cmd_res_t r;
    longint dx, dy, distance;
    logic [31:0] b32;
    logic [15:0] b16, e16;
    longint herr;
    dx = longint'(cfg_m.target_x) - longint'(p.pos_x);
    dy = longint'(cfg_m.target_y) - longint'(p.pos_y);
    distance = floor_sqrt(longint'(dx * dx) + longint'(dy * dy));
    b32 = compass_bearing(dx, dy) + 32'h8000;
    b16 = b32[31:16];
    e16 = b16 - p.yaw;
    herr = longint'($signed(e16));
    if (!(herr > -16384 && herr < 16384)) distance = -distance;
    r.drive_cmd = leaky_pi(drive_integ, distance, cfg_m.drive_p_gain,
                           cfg_m.drive_i_gain, cfg_m.drive_i_decay);
    r.steer_cmd = leaky_pi(steer_integ, herr, cfg_m.steer_p_gain,
                           cfg_m.steer_i_gain, cfg_m.steer_i_decay);
    r.distance = distance[25:0];
    r.herr = e16;
    return r;
  endfunction

  // pose transfer driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_q.push_back(predict_commands(pose_q.pop_front()));
        poses_sent++;
      end
      if ((!in_tvalid || in_tready)) begin
        if (pose_q.size() > 0 && !tx_pause && $urandom_range(99) >= idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pose_q[0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // command transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        cmd_res_t a, x;
        a.drive_cmd = out_tdata[31:0];
        a.steer_cmd = out_tdata[63:32];
        a.distance  = out_tdata[89:64];
        a.herr      = out_tdata[105:90];
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transfer %0d", results_seen);
        end else begin
          x = expected_q.pop_front();
          if (a != x) begin
            errors++;
            if (errors <= 10)
              $display("mismatch #%0d: exp drv %0d str %0d dist %0d herr %0d, got %0d %0d %0d %0d",
                       results_seen, x.drive_cmd, x.steer_cmd, x.distance, x.herr,
                       a.drive_cmd, a.steer_cmd, a.distance, a.herr);
          end
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n ||
        (pose_q.size() == 0 && expected_q.size() == 0)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("tb_go_to_point_pi_controller: FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      gtp_pkg::REG_TARGET_X:      cfg_m.target_x      = val;
      gtp_pkg::REG_TARGET_Y:      cfg_m.target_y      = val;
      gtp_pkg::REG_DRIVE_P_GAIN:  cfg_m.drive_p_gain  = val[15:0];
      gtp_pkg::REG_DRIVE_I_GAIN:  cfg_m.drive_i_gain  = val[15:0];
      gtp_pkg::REG_DRIVE_I_DECAY: cfg_m.drive_i_decay = val[15:0];
      gtp_pkg::REG_STEER_P_GAIN:  cfg_m.steer_p_gain  = val[15:0];
      gtp_pkg::REG_STEER_I_GAIN:  cfg_m.steer_i_gain  = val[15:0];
      default:                    cfg_m.steer_i_decay = val[15:0];
    endcase
  endtask

  task automatic drain;
    wait (pose_q.size() == 0 && !in_tvalid && expected_q.size() == 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic load_setting(logic [23:0] tx, ty, logic [15:0] dp, di, dd, sp, si, sd);
    write_reg(gtp_pkg::REG_TARGET_X, tx);
    write_reg(gtp_pkg::REG_TARGET_Y, ty);
    write_reg(gtp_pkg::REG_DRIVE_P_GAIN, {8'd0, dp});
    write_reg(gtp_pkg::REG_DRIVE_I_GAIN, {8'd0, di});
    write_reg(gtp_pkg::REG_DRIVE_I_DECAY, {8'd0, dd});
    write_reg(gtp_pkg::REG_STEER_P_GAIN, {8'd0, sp});
    write_reg(gtp_pkg::REG_STEER_I_GAIN, {8'd0, si});
    write_reg(gtp_pkg::REG_STEER_I_DECAY, {8'd0, sd});
  endtask

  // random pose: mostly near the target, sometimes anywhere
  function automatic pose_t rand_pose();
    pose_t p;
    int span;
    p.yaw = 16'($urandom());
    case ($urandom_range(3))
      0: begin
        p.pos_x = 24'($urandom());
        p.pos_y = 24'($urandom());
      end
      default: begin
        span = 1 << $urandom_range(12);
        p.pos_x = 24'(cfg_m.target_x + $signed($urandom_range(2 * span)) - span);
        p.pos_y = 24'(cfg_m.target_y + $signed($urandom_range(2 * span)) - span);
      end
    endcase
    return p;
  endfunction

  initial begin
    pose_t p;
    cfg_m = '0;
    drive_integ = 0;
    steer_integ = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes of fields and registers, target reached, sideways, behind
    load_setting(24'h7FFFFF, 24'h800000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 16'hFFFF, 16'hFFFF);
    pose_q.push_back('{yaw: 16'h0000, pos_y: 24'sh7FFFFF, pos_x: -24'sh800000});
    pose_q.push_back('{yaw: 16'hFFFF, pos_y: 24'sh7FFFFF, pos_x: -24'sh800000});
    pose_q.push_back('{yaw: 16'h4000, pos_y: 24'sh800000, pos_x: 24'sh7FFFFF});
    pose_q.push_back('{yaw: 16'h8000, pos_y: 24'sh000000, pos_x: 24'sh000000});
    pose_q.push_back('{yaw: 16'hC000, pos_y: -24'sh800000, pos_x: 24'sh7FFFFF});
    for (int i = 0; i < 6; i++)
      pose_q.push_back('{yaw: 16'h0000, pos_y: 24'sh7FFFFF, pos_x: -24'sh800000});
    drain();
    load_setting(24'd0, 24'd0, 16'd256, 16'd64, 16'hF000, 16'd512, 16'd32, 16'hE000);
    pose_q.push_back('{yaw: 16'h0000, pos_y: 24'sd0, pos_x: 24'sd0});
    pose_q.push_back('{yaw: 16'h8000, pos_y: 24'sd0, pos_x: 24'sd0});
    pose_q.push_back('{yaw: 16'h0000, pos_y: -24'sd100, pos_x: 24'sd0});
    pose_q.push_back('{yaw: 16'h4000, pos_y: -24'sd100, pos_x: 24'sd0});
    pose_q.push_back('{yaw: 16'hC000, pos_y: -24'sd100, pos_x: 24'sd0});
    pose_q.push_back('{yaw: 16'h8000, pos_y: -24'sd100, pos_x: 24'sd0});
    pose_q.push_back('{yaw: 16'h0000, pos_y: 24'sd100, pos_x: 24'sd0});
    pose_q.push_back('{yaw: 16'h3FFF, pos_y: 24'sd0, pos_x: -24'sd50});
    pose_q.push_back('{yaw: 16'h4001, pos_y: -24'sd50, pos_x: 24'sd0});
    pose_q.push_back('{yaw: 16'h0000, pos_y: 24'sd0, pos_x: 24'sd1});
    drain();

    // random phases with fresh settings; phase 1 idles never
    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = (ph == 1) ? 0 : 14;
      case (ph)
        0: load_setting('0, '0, '0, '0, '0, '0, '0, '0);
        7: load_setting(24'h800000, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: load_setting(24'($urandom()), 24'($urandom()), 16'($urandom()),
                              16'($urandom()), 16'($urandom_range(65535, 49152)),
                              16'($urandom()), 16'($urandom()),
                              16'($urandom_range(65535, 32768)));
      endcase
      for (int i = 0; i < 215; i++) begin
        if (i == 120 && ph == 3) begin
          wait (pose_q.size() == 0 && !in_tvalid);
          tx_pause = 1'b1;
          wait (expected_q.size() == 0);
          repeat (20) @(posedge clk);
          tx_pause = 1'b0;
        end
        p = rand_pose();
        pose_q.push_back(p);
        if (i == 100 && ph == 2) hold_off = 600;
        if (pose_q.size() > 8) wait (pose_q.size() <= 4);
      end
      drain();
    end

    $display("covered %0d poses, %0d result transfers, 10 register settings",
             poses_sent, results_seen);
    if (errors == 0) begin
      $display("tb_go_to_point_pi_controller: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_go_to_point_pi_controller: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
design/gtp_pkg.sv
design/gtp_datapath.sv
design/gtp_ctrl.sv
design/go_to_point_pi_controller.sv
tb/tb_go_to_point_pi_controller.sv
